>>> src/one_shot_action_timer_table_defines.svh
// ----------------------------------------------------------------------------
// One-shot action timer table: assertion macros
// Shared property macros, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_ACTION_TIMER_TABLE_DEFINES_SVH
`define ONE_SHOT_ACTION_TIMER_TABLE_DEFINES_SVH

// same-cycle implication
`define OSAT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OSAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/osat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osat_pkg
// Types and fixed constants of the one-shot action timer table.
// ----------------------------------------------------------------------------
package osat_pkg;

    localparam int SEC_W      = 32;
    localparam int MS_W       = 10;
    localparam int EMS_W      = 20;
    localparam int IN_TAG_W   = 8;
    localparam int KIND_W     = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int TAG_OUT_W  = 8;
    localparam int MS_PER_S   = 1000;
    localparam int MAX_FIRE   = 16;
    localparam int FIRE_CNT_W = $clog2(MAX_FIRE + 1);

    // x / 1000 == (x * ceil(2^30 / 1000)) >> 30 for every 20-bit x
    localparam int MS_RECIP       = 1073742;
    localparam int MS_RECIP_W     = 21;
    localparam int MS_RECIP_SHIFT = 30;
    localparam int QUO_W          = EMS_W + MS_RECIP_W - MS_RECIP_SHIFT;

    typedef enum logic [KIND_W-1:0] {
        KIND_SCHED = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_FIRED = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic {
        CMD_SCHEDULE = 1'b0,
        CMD_TICK     = 1'b1
    } t_cmd;

endpackage

>>> src/one_shot_action_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_action_timer_table
// A table of one-shot timers with schedule and tick commands.
// ----------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low; o_busy falls at
// the clock edge that puts the last result of that command on the ports.
// Results appear on o_kind/o_slot/o_fired_tag/o_last for one cycle each,
// marked by o_strobe, and cannot be held off. A schedule command splits
// i_extra_ms into seconds and milliseconds with a multiply by the reciprocal
// of 1000 in ST_DIV, whose quotient is registered in r_quo, and a
// back-multiply and subtract in ST_PLACE, which registers the result. A tick
// reads the entry memory through its single read port, one slot per cycle,
// and stops reading early once 16 entries have fired; fired results stream
// out as they are found, the final one carrying o_last. The table is usable
// right after reset.
`include "one_shot_action_timer_table_defines.svh"

module one_shot_action_timer_table
    import osat_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TAG_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_cmd,
    input  logic [SEC_W-1:0]      i_target_seconds,
    input  logic [EMS_W-1:0]      i_extra_ms,
    input  logic [IN_TAG_W-1:0]   i_action_tag,
    input  logic [SEC_W-1:0]      i_now_seconds,
    input  logic [MS_W-1:0]       i_now_millis,
    output logic                  o_strobe,
    output logic [KIND_W-1:0]     o_kind,
    output logic [SLOT_OUT_W-1:0] o_slot,
    output logic [TAG_OUT_W-1:0]  o_fired_tag,
    output logic                  o_last
);

    localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int SLOT_EXT_W = (IDX_W > SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;
    localparam int TAG_EXT_W  = (TAG_BITS > TAG_OUT_W) ? TAG_BITS : TAG_OUT_W;
    localparam int ENTRY_W    = SEC_W + MS_W + TAG_BITS;
    localparam int PROD_W     = EMS_W + MS_RECIP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PLACE,
        ST_SCAN
    } t_state;

    t_state                  r_state;
    logic [NUM_SLOTS-1:0]    r_active;
    logic [SEC_W-1:0]        r_tsec;
    logic [EMS_W-1:0]        r_div;
    logic [QUO_W-1:0]        r_quo;
    logic [TAG_BITS-1:0]     r_tag;
    logic [SEC_W+MS_W-1:0]   r_now;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_pipe_vld;
    logic [IDX_W-1:0]        r_cmp_idx;
    logic                    r_pend_vld;
    logic [IDX_W-1:0]        r_pend_idx;
    logic [TAG_BITS-1:0]     r_pend_tag;
    logic [FIRE_CNT_W-1:0]   r_fire_cnt;
    logic                    r_out_vld;
    logic [KIND_W-1:0]       r_out_kind;
    logic [SLOT_OUT_W-1:0]   r_out_slot;
    logic [TAG_OUT_W-1:0]    r_out_tag;
    logic                    r_out_last;

    logic [ENTRY_W-1:0]      r_mem [NUM_SLOTS];
    logic [ENTRY_W-1:0]      r_rd_data;

    // whole seconds of the millisecond offset by reciprocal multiply
    logic [PROD_W-1:0]       div_prod;
    logic [QUO_W-1:0]        n_quo;
    logic [EMS_W-1:0]        quo_ms;
    logic [EMS_W-1:0]        rem_full;
    logic [MS_W-1:0]         place_ms;

    logic [SEC_W:0]          sec_sum;
    logic [SEC_W-1:0]        sec_sat;

    logic                    free_any;
    logic [IDX_W-1:0]        free_idx;
    logic [SLOT_EXT_W-1:0]   free_slot_ext;

    logic [SEC_W-1:0]        rd_sec;
    logic [MS_W-1:0]         rd_ms;
    logic [TAG_BITS-1:0]     rd_tag;
    logic                    cmp_due;
    logic [FIRE_CNT_W-1:0]   fire_total;
    logic                    scan_issue;
    logic                    mem_we;

    logic [SLOT_EXT_W-1:0]   pend_slot_ext;
    logic [TAG_EXT_W-1:0]    pend_tag_ext;

    assign div_prod = PROD_W'(r_div) * PROD_W'(MS_RECIP);
    assign n_quo    = div_prod[PROD_W-1 -: QUO_W];

    // r_quo holds the quotient in the place cycle
    assign quo_ms   = EMS_W'(r_quo) * EMS_W'(MS_PER_S);
    assign rem_full = r_div - quo_ms;
    assign place_ms = rem_full[MS_W-1:0];

    assign sec_sum = {1'b0, r_tsec} + (SEC_W+1)'(r_quo);
    assign sec_sat = sec_sum[SEC_W] ? {SEC_W{1'b1}} : sec_sum[SEC_W-1:0];

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign free_slot_ext = SLOT_EXT_W'(free_idx);
    assign pend_slot_ext = SLOT_EXT_W'(r_pend_idx);
    assign pend_tag_ext  = TAG_EXT_W'(r_pend_tag);

    assign rd_sec = r_rd_data[ENTRY_W-1 -: SEC_W];
    assign rd_ms  = r_rd_data[TAG_BITS +: MS_W];
    assign rd_tag = r_rd_data[TAG_BITS-1:0];

    assign cmp_due    = r_pipe_vld && r_active[r_cmp_idx] && (r_now >= {rd_sec, rd_ms});
    assign fire_total = r_fire_cnt + FIRE_CNT_W'(cmp_due);
    // stop reading once the fire budget of this tick is used up
    assign scan_issue = (r_state == ST_SCAN) && (r_idx < CNT_W'(NUM_SLOTS))
                        && (fire_total < FIRE_CNT_W'(MAX_FIRE));
    assign mem_we     = (r_state == ST_PLACE) && free_any;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[free_idx] <= {sec_sat, place_ms, r_tag};
        end
        if (scan_issue) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_active   <= '0;
            r_pipe_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        if (t_cmd'(i_cmd) == CMD_TICK) begin
                            r_now      <= {i_now_seconds, i_now_millis};
                            r_idx      <= '0;
                            r_fire_cnt <= '0;
                            r_pend_vld <= 1'b0;
                            r_pipe_vld <= 1'b0;
                            r_state    <= ST_SCAN;
                        end else begin
                            r_tsec  <= i_target_seconds;
                            r_div   <= i_extra_ms;
                            r_tag   <= TAG_BITS'(i_action_tag);
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_quo   <= n_quo;
                    r_state <= ST_PLACE;
                end
                ST_PLACE: begin
                    r_out_vld  <= 1'b1;
                    r_out_tag  <= '0;
                    r_out_last <= 1'b1;
                    if (free_any) begin
                        r_active[free_idx] <= 1'b1;
                        r_out_kind         <= KIND_SCHED;
                        r_out_slot         <= free_slot_ext[SLOT_OUT_W-1:0];
                    end else begin
                        r_out_kind <= KIND_FULL;
                        r_out_slot <= '0;
                    end
                    r_state <= ST_IDLE;
                end
                ST_SCAN: begin
                    r_pipe_vld <= scan_issue;
                    if (scan_issue) begin
                        r_cmp_idx <= r_idx[IDX_W-1:0];
                        r_idx     <= r_idx + CNT_W'(1);
                    end
                    if (cmp_due) begin
                        r_active[r_cmp_idx] <= 1'b0;
                        r_fire_cnt          <= fire_total;
                        r_pend_vld          <= 1'b1;
                        r_pend_idx          <= r_cmp_idx;
                        r_pend_tag          <= rd_tag;
                        // a newer fire means the held one is not the last
                        if (r_pend_vld) begin
                            r_out_vld  <= 1'b1;
                            r_out_kind <= KIND_FIRED;
                            r_out_slot <= pend_slot_ext[SLOT_OUT_W-1:0];
                            r_out_tag  <= pend_tag_ext[TAG_OUT_W-1:0];
                            r_out_last <= 1'b0;
                        end
                    end else if (!scan_issue && !r_pipe_vld) begin
                        r_out_vld  <= 1'b1;
                        r_out_last <= 1'b1;
                        if (r_pend_vld) begin
                            r_out_kind <= KIND_FIRED;
                            r_out_slot <= pend_slot_ext[SLOT_OUT_W-1:0];
                            r_out_tag  <= pend_tag_ext[TAG_OUT_W-1:0];
                        end else begin
                            r_out_kind <= KIND_NONE;
                            r_out_slot <= '0;
                            r_out_tag  <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_strobe    = r_out_vld;
    assign o_kind      = r_out_kind;
    assign o_slot      = r_out_slot;
    assign o_fired_tag = r_out_tag;
    assign o_last      = r_out_last;

    `OSAT_ASSERT_SAME(a_single_result_last, r_out_vld && (r_out_kind != KIND_FIRED), r_out_last, "schedule or idle tick result without last")
    `OSAT_ASSERT_SAME(a_strobe_from_busy, r_out_vld, $past(r_state != ST_IDLE), "result shown without a command in progress")
    `OSAT_ASSERT_NEXT(a_transfer_goes_busy, i_start && !o_busy, o_busy, "accepted command did not raise busy")
    `OSAT_ASSERT_SAME(a_fire_budget, r_pipe_vld && (r_state == ST_SCAN), r_fire_cnt < FIRE_CNT_W'(MAX_FIRE), "slot read after fire budget was spent")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: one-shot action timer table
// Issues schedule and tick commands through the start/busy handshake and checks
// every strobed result against a cycle-free model of the timer table. A short
// directed table comes first, then randomized time-lines with bursts and noise.
// ----------------------------------------------------------------------------
module tb
    import osat_pkg::*;
;

    localparam int NUM_SLOTS    = 16;
    localparam int TAG_BITS     = 8;
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_LIMIT  = 1000;

    typedef struct {
        t_cmd                  cmd;
        logic [SEC_W-1:0]      tsec;
        logic [EMS_W-1:0]      ems;
        logic [IN_TAG_W-1:0]   tag;
        logic [SEC_W-1:0]      nsec;
        logic [MS_W-1:0]       nms;
        bit                    typed;
        t_kind                 kind;
        logic [SLOT_OUT_W-1:0] slot;
    } t_timer_cmd;

    typedef struct {
        t_kind                 kind;
        logic [SLOT_OUT_W-1:0] slot;
        logic [TAG_OUT_W-1:0]  tag;
        logic                  last;
    } t_timer_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic                  i_cmd;
    logic [SEC_W-1:0]      i_target_seconds;
    logic [EMS_W-1:0]      i_extra_ms;
    logic [IN_TAG_W-1:0]   i_action_tag;
    logic [SEC_W-1:0]      i_now_seconds;
    logic [MS_W-1:0]       i_now_millis;
    logic                  o_strobe;
    logic [KIND_W-1:0]     o_kind;
    logic [SLOT_OUT_W-1:0] o_slot;
    logic [TAG_OUT_W-1:0]  o_fired_tag;
    logic                  o_last;

    // model of the table
    bit                    slot_live [NUM_SLOTS];
    logic [SEC_W-1:0]      slot_secs [NUM_SLOTS];
    logic [MS_W-1:0]       slot_msec [NUM_SLOTS];
    logic [TAG_BITS-1:0]   slot_tag  [NUM_SLOTS];

    t_timer_result pending_results[$];
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    int            no_idle_run    = 0;

    one_shot_action_timer_table #(
        .NUM_SLOTS(NUM_SLOTS),
        .TAG_BITS (TAG_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_cmd           (i_cmd),
        .i_target_seconds(i_target_seconds),
        .i_extra_ms      (i_extra_ms),
        .i_action_tag    (i_action_tag),
        .i_now_seconds   (i_now_seconds),
        .i_now_millis    (i_now_millis),
        .o_strobe        (o_strobe),
        .o_kind          (o_kind),
        .o_slot          (o_slot),
        .o_fired_tag     (o_fired_tag),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // fields of the other command are filled with junk
    function automatic t_timer_cmd mk_row(t_cmd cmd, logic [31:0] a, logic [19:0] b,
                                          logic [7:0] tag, bit typed, t_kind kind,
                                          logic [3:0] slot);
        t_timer_cmd c;
        c.cmd   = cmd;
        c.tsec  = $urandom;
        c.ems   = EMS_W'($urandom);
        c.tag   = IN_TAG_W'($urandom);
        c.nsec  = $urandom;
        c.nms   = MS_W'($urandom);
        c.typed = typed;
        c.kind  = kind;
        c.slot  = slot;
        if (cmd == CMD_SCHEDULE) begin
            c.tsec = a;
            c.ems  = b;
            c.tag  = tag;
        end else begin
            c.nsec = a;
            c.nms  = b[MS_W-1:0];
        end
        return c;
    endfunction

    function automatic void advance_timer_table(t_timer_cmd c);
        longint unsigned secs;
        int              free_slot;
        int              fired;
        free_slot = -1;
        fired     = 0;
        if (c.cmd == CMD_SCHEDULE) begin
            secs = 64'(c.tsec);
            secs += 64'(c.ems / MS_PER_S);
            if (secs > 64'hFFFF_FFFF)
                secs = 64'hFFFF_FFFF;
            for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                if (!slot_live[i])
                    free_slot = i;
            end
            if (free_slot >= 0) begin
                slot_live[free_slot] = 1'b1;
                slot_secs[free_slot] = secs[SEC_W-1:0];
                slot_msec[free_slot] = MS_W'(c.ems % MS_PER_S);
                slot_tag[free_slot]  = TAG_BITS'(c.tag);
                pending_results.push_back('{KIND_SCHED, SLOT_OUT_W'(free_slot), '0, 1'b1});
            end else begin
                pending_results.push_back('{KIND_FULL, '0, '0, 1'b1});
            end
        end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (fired < MAX_FIRE && slot_live[i] &&
                    (c.nsec > slot_secs[i] ||
                     (c.nsec == slot_secs[i] && c.nms >= slot_msec[i]))) begin
                    slot_live[i] = 1'b0;
                    pending_results.push_back('{KIND_FIRED, SLOT_OUT_W'(i),
                                                TAG_OUT_W'(slot_tag[i]), 1'b0});
                    fired++;
                end
            end
            if (fired == 0)
                pending_results.push_back('{KIND_NONE, '0, '0, 1'b1});
            else
                pending_results[pending_results.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic issue_cmd(t_timer_cmd c);
        int depth_before;
        i_start          <= 1'b1;
        i_cmd            <= c.cmd;
        i_target_seconds <= c.tsec;
        i_extra_ms       <= c.ems;
        i_action_tag     <= c.tag;
        i_now_seconds    <= c.nsec;
        i_now_millis     <= c.nms;
        do @(posedge i_clk); while (o_busy);
        depth_before = pending_results.size();
        advance_timer_table(c);
        if (c.typed) begin
            while (pending_results.size() > depth_before)
                void'(pending_results.pop_back());
            pending_results.push_back('{c.kind, c.slot, '0, 1'b1});
        end
        @(negedge i_clk);
    endtask

    task automatic idle_between(bit drain);
        int gap;
        int r;
        gap = 0;
        r   = $urandom_range(0, 99);
        if (no_idle_run > 0)
            no_idle_run--;
        else if (r >= 50 && r < 80)
            gap = $urandom_range(1, 4);
        else if (r >= 80 && r < 93)
            gap = $urandom_range(5, 25);
        else if (r >= 93 && r < 97)
            gap = $urandom_range(26, 80);
        else if (r >= 97)
            no_idle_run = $urandom_range(10, 40);
        if (drain || $urandom_range(0, 99) == 0) begin
            // hold off until the table has answered everything
            i_start <= 1'b0;
            do @(negedge i_clk); while (pending_results.size() != 0);
        end else if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: unexpected result, expected none, got kind %0d slot %0d",
                         $time, o_kind, o_slot);
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 8'(want.kind), 8'(o_kind));
                check_field("slot", 8'(want.slot), 8'(o_slot));
                check_field("fired_tag", want.tag, o_fired_tag);
                check_field("last", 8'(want.last), 8'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        t_timer_cmd      dir_rows[$];
        t_timer_cmd      c;
        longint unsigned secs;
        logic [SEC_W-1:0] cur_sec;
        int              cur_ms;
        int              burst_left;
        int              r;
        logic [EMS_W-1:0] ems;
        logic [MS_W-1:0] nms;

        burst_left       = 0;
        cur_sec          = '0;
        cur_ms           = 0;
        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_cmd            = CMD_SCHEDULE;
        i_target_seconds = '0;
        i_extra_ms       = '0;
        i_action_tag     = '0;
        i_now_seconds    = '0;
        i_now_millis     = '0;

        // empty table, then both ends of the seconds range
        dir_rows.push_back(mk_row(CMD_TICK, 32'd0, 20'd0, 8'd0, 1, KIND_NONE, 4'd0));
        dir_rows.push_back(mk_row(CMD_SCHEDULE, 32'd0, 20'd0, 8'hFF, 1, KIND_SCHED, 4'd0));
        dir_rows.push_back(mk_row(CMD_SCHEDULE, 32'hFFFF_FFFF, 20'hFFFFF, 8'h00,
                                  1, KIND_SCHED, 4'd1));
        // lands exactly on the maximum second without saturating
        dir_rows.push_back(mk_row(CMD_SCHEDULE, 32'hFFFF_FBE7, 20'hFFFFF, 8'hA5,
                                  1, KIND_SCHED, 4'd2));
        dir_rows.push_back(mk_row(CMD_SCHEDULE, 32'd10, 20'd999, 8'h5A, 1, KIND_SCHED, 4'd3));
        dir_rows.push_back(mk_row(CMD_SCHEDULE, 32'd10, 20'd1000, 8'h3C, 1, KIND_SCHED, 4'd4));
        // millisecond boundary on equal seconds, then millis above 999
        dir_rows.push_back(mk_row(CMD_TICK, 32'd10, 20'd998, 8'd0, 0, KIND_NONE, 4'd0));
        dir_rows.push_back(mk_row(CMD_TICK, 32'd10, 20'd999, 8'd0, 0, KIND_NONE, 4'd0));
        dir_rows.push_back(mk_row(CMD_TICK, 32'd11, 20'd1023, 8'd0, 0, KIND_NONE, 4'd0));
        for (int k = 0; k < 14; k++)
            dir_rows.push_back(mk_row(CMD_SCHEDULE, 32'd100 + 3 * k, 20'(k * 250),
                                      8'h10 + 8'(k), 0, KIND_SCHED, 4'd0));
        dir_rows.push_back(mk_row(CMD_SCHEDULE, 32'd5, 20'd5, 8'h77, 1, KIND_FULL, 4'd0));
        // every slot due at once
        dir_rows.push_back(mk_row(CMD_TICK, 32'hFFFF_FFFF, 20'h3FF, 8'd0, 0, KIND_NONE, 4'd0));
        dir_rows.push_back(mk_row(CMD_TICK, 32'd0, 20'd0, 8'd0, 1, KIND_NONE, 4'd0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            issue_cmd(dir_rows[k]);
            idle_between(k == dir_rows.size() - 1);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: cur_sec = $urandom_range(0, 20);
                    1: cur_sec = 32'hFFFF_FFFF - $urandom_range(0, 12);
                    default: cur_sec = $urandom;
                endcase
                cur_ms = $urandom_range(0, 999);
            end
            r = $urandom_range(0, 99);
            if (burst_left > 0) begin
                burst_left--;
                r = 0;
            end else if (r < 3) begin
                burst_left = 15;
            end
            if (r < 45) begin
                // schedule a little ahead of (or just behind) the current time
                secs = 64'(cur_sec);
                if ($urandom_range(0, 9) == 0)
                    secs = (secs > 3) ? secs - 64'($urandom_range(0, 3)) : 64'd0;
                else
                    secs += 64'($urandom_range(0, 3));
                if (secs > 64'hFFFF_FFFF)
                    secs = 64'hFFFF_FFFF;
                ems = ($urandom_range(0, 6) == 0) ? EMS_W'($urandom_range(0, 20'hFFFFF))
                                                  : EMS_W'($urandom_range(0, 4999));
                c = mk_row(CMD_SCHEDULE, secs[31:0], ems, 8'($urandom), 0, KIND_SCHED, 4'd0);
            end else if (r < 85) begin
                cur_ms += $urandom_range(0, 2500);
                secs = 64'(cur_sec);
                secs += 64'(cur_ms / 1000);
                cur_ms = cur_ms % 1000;
                if (secs > 64'hFFFF_FFFF)
                    secs = 64'hFFFF_FFFF;
                cur_sec = secs[31:0];
                nms = ($urandom_range(0, 9) == 0) ? MS_W'($urandom_range(1000, 1023))
                                                  : MS_W'(cur_ms);
                c = mk_row(CMD_TICK, cur_sec, 20'(nms), 8'd0, 0, KIND_NONE, 4'd0);
            end else if (r < 90) begin
                c = mk_row(CMD_TICK, 32'hFFFF_FFFF, 20'h3FF, 8'd0, 0, KIND_NONE, 4'd0);
            end else begin
                c = mk_row(t_cmd'($urandom_range(0, 1)), $urandom, 20'($urandom),
                           8'($urandom), 0, KIND_NONE, 4'd0);
            end
            issue_cmd(c);
            idle_between(0);
        end

        i_start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
